// ----- design/srtmb_pkg.sv -----
// Package for the scale-rotate-translate matrix builder.
// Holds field types, the CORDIC arctangent table and the micro-program of the back end.
// No dependencies.
package srtmb_pkg;

    localparam int WORD_W            = 32;
    localparam int DEF_FRACTION_BITS = 16;
    localparam int N_AXES            = 3;
    localparam int IN_W              = 9 * WORD_W;
    localparam int OUT_W             = 4 * WORD_W;
    localparam int QDEPTH            = 2;

    // Q2.30 working words carry two guard bits.
    localparam int CW                = 34;
    localparam int CORDIC_STEPS      = 30;
    localparam int CORDIC_GAIN_INV   = 652032874;
    localparam int DEG_TO_RAD_Q32    = 74961321;
    localparam logic signed [CW-1:0] Q30_ONE = 34'sd1073741824;

    localparam int RF_DEPTH = 36;
    localparam int RF_AW    = 6;
    localparam int MAT_N    = 9;
    localparam int PROG_LEN = 47;
    localparam int PC_W     = 6;
    localparam logic [1:0] LAST_COL = 2'd3;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic signed [CW-1:0] cword_t;

    typedef struct packed {
        logic [N_AXES-1:0][WORD_W-1:0] move;
        logic [N_AXES-1:0][WORD_W-1:0] angle;
        logic [N_AXES-1:0][WORD_W-1:0] scale;
    } in_item_t;

    typedef enum logic [2:0] {
        OP_MUL,
        OP_ADD,
        OP_SUB,
        OP_ONEM2,
        OP_DADD,
        OP_DSUB,
        OP_SMUL
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [RF_AW-1:0] a;
        logic [RF_AW-1:0] b;
        logic [RF_AW-1:0] dst;
    } step_t;

    // Register file map.
    localparam int R_SX  = 0;
    localparam int R_CX  = 1;
    localparam int R_SY  = 2;
    localparam int R_CY  = 3;
    localparam int R_SZ  = 4;
    localparam int R_CZ  = 5;
    localparam int R_SC0 = 6;
    localparam int R_SC1 = 7;
    localparam int R_SC2 = 8;
    localparam int R_T0  = 10;
    localparam int R_T1  = 11;
    localparam int R_T2  = 12;
    localparam int R_T3  = 13;
    localparam int R_QW  = 14;
    localparam int R_QX  = 15;
    localparam int R_QY  = 16;
    localparam int R_QZ  = 17;
    localparam int R_XX  = 18;
    localparam int R_YY  = 19;
    localparam int R_ZZ  = 20;
    localparam int R_XY  = 21;
    localparam int R_XZ  = 22;
    localparam int R_YZ  = 23;
    localparam int R_WX  = 24;
    localparam int R_WY  = 25;
    localparam int R_WZ  = 26;
    localparam int R_E00 = 27;

    function automatic step_t mk(input op_t op, input int a, input int b, input int d);
        step_t s;
        s.op  = op;
        s.a   = RF_AW'(a);
        s.b   = RF_AW'(b);
        s.dst = RF_AW'(d);
        return s;
    endfunction

    // For the scaling steps dst is the matrix slot 3*col+row.
    function automatic step_t prog_step(input logic [PC_W-1:0] pc);
        step_t s;
        case (pc)
            6'd0:  s = mk(OP_MUL, R_CX, R_CY, R_T0);
            6'd1:  s = mk(OP_MUL, R_T0, R_CZ, R_T1);
            6'd2:  s = mk(OP_MUL, R_SX, R_SY, R_T2);
            6'd3:  s = mk(OP_MUL, R_T2, R_SZ, R_T3);
            6'd4:  s = mk(OP_ADD, R_T1, R_T3, R_QW);
            6'd5:  s = mk(OP_MUL, R_SX, R_CY, R_T0);
            6'd6:  s = mk(OP_MUL, R_T0, R_CZ, R_T1);
            6'd7:  s = mk(OP_MUL, R_CX, R_SY, R_T2);
            6'd8:  s = mk(OP_MUL, R_T2, R_SZ, R_T3);
            6'd9:  s = mk(OP_SUB, R_T1, R_T3, R_QX);
            6'd10: s = mk(OP_MUL, R_CX, R_SY, R_T0);
            6'd11: s = mk(OP_MUL, R_T0, R_CZ, R_T1);
            6'd12: s = mk(OP_MUL, R_SX, R_CY, R_T2);
            6'd13: s = mk(OP_MUL, R_T2, R_SZ, R_T3);
            6'd14: s = mk(OP_ADD, R_T1, R_T3, R_QY);
            6'd15: s = mk(OP_MUL, R_CX, R_CY, R_T0);
            6'd16: s = mk(OP_MUL, R_T0, R_SZ, R_T1);
            6'd17: s = mk(OP_MUL, R_SX, R_SY, R_T2);
            6'd18: s = mk(OP_MUL, R_T2, R_CZ, R_T3);
            6'd19: s = mk(OP_SUB, R_T1, R_T3, R_QZ);
            6'd20: s = mk(OP_MUL, R_QX, R_QX, R_XX);
            6'd21: s = mk(OP_MUL, R_QY, R_QY, R_YY);
            6'd22: s = mk(OP_MUL, R_QZ, R_QZ, R_ZZ);
            6'd23: s = mk(OP_MUL, R_QX, R_QY, R_XY);
            6'd24: s = mk(OP_MUL, R_QX, R_QZ, R_XZ);
            6'd25: s = mk(OP_MUL, R_QY, R_QZ, R_YZ);
            6'd26: s = mk(OP_MUL, R_QW, R_QX, R_WX);
            6'd27: s = mk(OP_MUL, R_QW, R_QY, R_WY);
            6'd28: s = mk(OP_MUL, R_QW, R_QZ, R_WZ);
            6'd29: s = mk(OP_ONEM2, R_YY, R_ZZ, R_E00);
            6'd30: s = mk(OP_DADD, R_XY, R_WZ, R_E00 + 1);
            6'd31: s = mk(OP_DSUB, R_XZ, R_WY, R_E00 + 2);
            6'd32: s = mk(OP_DSUB, R_XY, R_WZ, R_E00 + 3);
            6'd33: s = mk(OP_ONEM2, R_XX, R_ZZ, R_E00 + 4);
            6'd34: s = mk(OP_DADD, R_YZ, R_WX, R_E00 + 5);
            6'd35: s = mk(OP_DADD, R_XZ, R_WY, R_E00 + 6);
            6'd36: s = mk(OP_DSUB, R_YZ, R_WX, R_E00 + 7);
            6'd37: s = mk(OP_ONEM2, R_XX, R_YY, R_E00 + 8);
            6'd38: s = mk(OP_SMUL, R_E00 + 0, R_SC0, 0);
            6'd39: s = mk(OP_SMUL, R_E00 + 1, R_SC0, 1);
            6'd40: s = mk(OP_SMUL, R_E00 + 2, R_SC0, 2);
            6'd41: s = mk(OP_SMUL, R_E00 + 3, R_SC1, 3);
            6'd42: s = mk(OP_SMUL, R_E00 + 4, R_SC1, 4);
            6'd43: s = mk(OP_SMUL, R_E00 + 5, R_SC1, 5);
            6'd44: s = mk(OP_SMUL, R_E00 + 6, R_SC2, 6);
            6'd45: s = mk(OP_SMUL, R_E00 + 7, R_SC2, 7);
            6'd46: s = mk(OP_SMUL, R_E00 + 8, R_SC2, 8);
            default: s = mk(OP_MUL, R_T0, R_T0, R_T0);
        endcase
        return s;
    endfunction

    function automatic logic [31:0] atan_q30(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'd843314856;
            5'd1:  v = 32'd497837829;
            5'd2:  v = 32'd263043836;
            5'd3:  v = 32'd133525158;
            5'd4:  v = 32'd67021686;
            5'd5:  v = 32'd33543515;
            5'd6:  v = 32'd16775850;
            5'd7:  v = 32'd8388437;
            5'd8:  v = 32'd4194282;
            5'd9:  v = 32'd2097149;
            5'd10: v = 32'd1048575;
            5'd11: v = 32'd524287;
            5'd12: v = 32'd262143;
            5'd13: v = 32'd131071;
            5'd14: v = 32'd65535;
            5'd15: v = 32'd32767;
            5'd16: v = 32'd16383;
            5'd17: v = 32'd8191;
            5'd18: v = 32'd4095;
            5'd19: v = 32'd2047;
            5'd20: v = 32'd1023;
            5'd21: v = 32'd511;
            5'd22: v = 32'd255;
            5'd23: v = 32'd127;
            5'd24: v = 32'd63;
            5'd25: v = 32'd31;
            5'd26: v = 32'd15;
            5'd27: v = 32'd7;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- design/srtmb_ram.sv -----
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
module srtmb_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 36
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ----- design/srtmb_front.sv -----
// Front end: takes input items off the stream and holds them in a two-entry queue.
// Depends on srtmb_pkg.
module srtmb_front import srtmb_pkg::*; (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    input  logic [IN_W-1:0] s_axis_tdata,
    output in_item_t        item,
    output logic            item_valid,
    input  logic            item_pop
);

    in_item_t   q_reg [QDEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    in_item_t   in_item;
    logic       push, pop;

    always_comb
    begin
        for (int k = 0; k < N_AXES; k++)
        begin
            in_item.scale[k] = s_axis_tdata[k*WORD_W +: WORD_W];
            in_item.angle[k] = s_axis_tdata[(N_AXES + k)*WORD_W +: WORD_W];
            in_item.move[k]  = s_axis_tdata[(2*N_AXES + k)*WORD_W +: WORD_W];
        end
    end

    assign s_axis_tready = (cnt_reg != 2'(QDEPTH));
    assign item_valid    = (cnt_reg != 2'd0);
    assign item          = q_reg[rd_ptr_reg];
    assign push          = s_axis_tvalid && s_axis_tready;
    assign pop           = item_pop && item_valid;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ----- design/srtmb_halfangle.sv -----
// Half-angle sine and cosine: modulo-360 reduction by reciprocal multiplication,
// conversion to Q2.30 radians, then a 30-step rotation-mode CORDIC. Depends on srtmb_pkg.
module srtmb_halfangle import srtmb_pkg::*; #(
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  word_t       angle,
    output logic        done,
    output cword_t      sin_h,
    output cword_t      cos_h
);

    localparam int FULL_W = FRACTION_BITS + 9;
    localparam int RW     = FULL_W + 1;
    localparam int DW     = RW + 1;
    localparam int PW     = DW + 28;
    localparam logic [63:0] FULL      = 64'd360 << FRACTION_BITS;
    localparam logic [63:0] OFF       = (64'd1 << 31) % FULL;
    localparam logic [63:0] HALF_TURN = 64'd180 << FRACTION_BITS;
    localparam logic [63:0] RND       = 64'd1 << (FRACTION_BITS + 2);
    // A full turn is 45 times 2^(FRACTION_BITS+3), so the low bits pass through and
    // only the bits above them are reduced modulo 45, by a reciprocal multiplication.
    localparam int LOW_W = FRACTION_BITS + 3;
    localparam int QW    = WORD_W - LOW_W;
    localparam int RSH   = QW + 6;
    localparam int MW    = 2 * QW + 1;
    localparam logic [63:0]   RECIP    = ((64'd1 << RSH) + 64'd44) / 64'd45;
    localparam logic [QW-1:0] TURN_DIV = QW'(45);

    typedef enum logic [6:0] {
        A_IDLE  = 7'b0000001,
        A_DIV   = 7'b0000010,
        A_MOD   = 7'b0000100,
        A_FIX   = 7'b0001000,
        A_MULT  = 7'b0010000,
        A_ROUND = 7'b0100000,
        A_ROT   = 7'b1000000
    } astate_t;

    astate_t state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic       done_reg, done_next;
    logic [RW-1:0] rem_reg, rem_next;
    logic [31:0]   u_reg, u_next;
    logic [QW-1:0] quo_reg, quo_next;
    logic signed [DW-1:0] d_reg, d_next;
    logic signed [PW-1:0] prod_reg, prod_next;
    cword_t x_reg, x_next, y_reg, y_next, z_reg, z_next;

    logic [QW-1:0] hi;
    logic [MW-1:0] qprod;
    logic [5:0]    mod_q;
    logic signed [DW-1:0] r0, r1;
    logic signed [PW-1:0] rnd;
    cword_t dx, dy, at;

    always_comb
    begin
        hi    = u_reg[WORD_W-1:LOW_W];
        qprod = MW'(hi) * MW'(RECIP);
        mod_q = 6'(hi - quo_reg * TURN_DIV);
        r0    = $signed({1'b0, rem_reg}) - $signed(DW'(OFF));
        r1    = (r0 < 0) ? r0 + $signed(DW'(FULL)) : r0;
        rnd   = prod_reg + $signed(PW'(RND));
        dx    = y_reg >>> cnt_reg;
        dy    = x_reg >>> cnt_reg;
        at    = $signed({2'b00, atan_q30(cnt_reg)});
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        rem_next   = rem_reg;
        u_next     = u_reg;
        quo_next   = quo_reg;
        d_next     = d_reg;
        prod_next  = prod_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        case (state_reg)
            A_IDLE:
            begin
                if (start)
                begin
                    // Offset by 2^31 so the reduction sees an unsigned value.
                    u_next     = angle ^ 32'h8000_0000;
                    state_next = A_DIV;
                end
            end
            A_DIV:
            begin
                quo_next   = QW'(qprod >> RSH);
                state_next = A_MOD;
            end
            A_MOD:
            begin
                rem_next   = RW'({mod_q, u_reg[LOW_W-1:0]});
                state_next = A_FIX;
            end
            A_FIX:
            begin
                d_next     = r1 - $signed(DW'(HALF_TURN));
                state_next = A_MULT;
            end
            A_MULT:
            begin
                prod_next  = d_reg * $signed(28'(DEG_TO_RAD_Q32));
                state_next = A_ROUND;
            end
            A_ROUND:
            begin
                z_next     = CW'(rnd >>> (FRACTION_BITS + 3));
                x_next     = CW'(CORDIC_GAIN_INV);
                y_next     = '0;
                cnt_next   = 5'd0;
                state_next = A_ROT;
            end
            A_ROT:
            begin
                if (!z_reg[CW-1])
                begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = z_reg - at;
                end
                else
                begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = z_reg + at;
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(CORDIC_STEPS - 1))
                begin
                    done_next  = 1'b1;
                    state_next = A_IDLE;
                end
            end
            default:
            begin
                state_next = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            cnt_reg   <= 5'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        u_reg    <= u_next;
        quo_reg  <= quo_next;
        d_reg    <= d_next;
        prod_reg <= prod_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
    end

    // The CORDIC runs on the half angle less 90 degrees.
    assign done  = done_reg;
    assign sin_h = x_reg;
    assign cos_h = -y_reg;

endmodule

// ----- design/srtmb_back.sv -----
// Back end: half-angle units, a micro-programmed multiply engine over a register-file
// RAM, and the column output buffer. Depends on srtmb_pkg, srtmb_halfangle, srtmb_ram.
module srtmb_back import srtmb_pkg::*; #(
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  in_item_t         item,
    input  logic             item_valid,
    output logic             item_pop,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata,
    output logic [1:0]       m_axis_tuser,
    output logic             m_axis_tlast
);

    typedef enum logic [6:0] {
        B_IDLE  = 7'b0000001,
        B_ANGLE = 7'b0000010,
        B_LOAD  = 7'b0000100,
        B_READ  = 7'b0001000,
        B_MULT  = 7'b0010000,
        B_WRITE = 7'b0100000,
        B_DONE  = 7'b1000000
    } bstate_t;

    localparam logic [WORD_W-1:0] ROW3_ONE = WORD_W'(64'd1 << FRACTION_BITS);
    localparam logic signed [2*CW-1:0] P_RND = 68'sd536870912;

    bstate_t state_reg, state_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    logic [3:0]      ld_reg, ld_next;
    logic [N_AXES-1:0][WORD_W-1:0] scale_reg, move_reg;
    logic signed [2*CW-1:0] prod_reg;
    cword_t opa_reg, opb_reg;
    word_t  mw_reg [MAT_N];
    logic [3*WORD_W-1:0] obuf_col_reg [N_AXES];
    logic [N_AXES-1:0][WORD_W-1:0] obuf_move_reg;
    logic       obuf_valid_reg, obuf_valid_next;
    logic [1:0] col_reg, col_next;

    logic   ha_start;
    logic   ha_done [N_AXES];
    cword_t ha_sin [N_AXES];
    cword_t ha_cos [N_AXES];

    step_t cur;
    logic  rf_we;
    logic [RF_AW-1:0] rf_waddr;
    logic [CW-1:0]    rf_wdata, rf_rdata_a, rf_rdata_b;
    cword_t ld_val, alu_val;
    logic signed [2*CW-1:0] rnd;
    logic signed [CW:0] s_add, s_sub;
    word_t sat_val;
    logic  load_obuf, out_fire;

    for (genvar g = 0; g < N_AXES; g++)
    begin : g_ha
        srtmb_halfangle #(
            .FRACTION_BITS(FRACTION_BITS)
        ) u_ha (
            .clk   (clk),
            .rst_n (rst_n),
            .start (ha_start),
            .angle (item.angle[g]),
            .done  (ha_done[g]),
            .sin_h (ha_sin[g]),
            .cos_h (ha_cos[g])
        );
    end

    srtmb_ram #(
        .WIDTH(CW),
        .DEPTH(RF_DEPTH)
    ) u_rf (
        .clk     (clk),
        .we      (rf_we),
        .waddr   (rf_waddr),
        .wdata   (rf_wdata),
        .raddr_a (cur.a),
        .rdata_a (rf_rdata_a),
        .raddr_b (cur.b),
        .rdata_b (rf_rdata_b)
    );

    assign cur      = prog_step(pc_reg);
    assign ha_start = (state_reg == B_IDLE) && item_valid;
    assign item_pop = ha_start;

    always_comb
    begin
        case (ld_reg)
            4'd0:    ld_val = ha_sin[0];
            4'd1:    ld_val = ha_cos[0];
            4'd2:    ld_val = ha_sin[1];
            4'd3:    ld_val = ha_cos[1];
            4'd4:    ld_val = ha_sin[2];
            4'd5:    ld_val = ha_cos[2];
            4'd6:    ld_val = CW'($signed(scale_reg[0]));
            4'd7:    ld_val = CW'($signed(scale_reg[1]));
            4'd8:    ld_val = CW'($signed(scale_reg[2]));
            default: ld_val = '0;
        endcase
    end

    // Products round to nearest with ties toward plus infinity.
    always_comb
    begin
        rnd   = (prod_reg + P_RND) >>> 30;
        s_add = (CW+1)'(opa_reg) + (CW+1)'(opb_reg);
        s_sub = (CW+1)'(opa_reg) - (CW+1)'(opb_reg);
        if (rnd > 68'sd2147483647)
        begin
            sat_val = 32'h7FFF_FFFF;
        end
        else if (rnd < -68'sd2147483648)
        begin
            sat_val = 32'h8000_0000;
        end
        else
        begin
            sat_val = WORD_W'(rnd);
        end
        case (cur.op)
            OP_MUL:   alu_val = CW'(rnd);
            OP_ADD:   alu_val = CW'(s_add);
            OP_SUB:   alu_val = CW'(s_sub);
            OP_ONEM2: alu_val = Q30_ONE - CW'(s_add <<< 1);
            OP_DADD:  alu_val = CW'(s_add <<< 1);
            OP_DSUB:  alu_val = CW'(s_sub <<< 1);
            default:  alu_val = '0;
        endcase
    end

    always_comb
    begin
        rf_we    = 1'b0;
        rf_waddr = cur.dst;
        rf_wdata = alu_val;
        if (state_reg == B_LOAD)
        begin
            rf_we    = 1'b1;
            rf_waddr = RF_AW'(ld_reg);
            rf_wdata = ld_val;
        end
        else if ((state_reg == B_WRITE) && (cur.op != OP_SMUL))
        begin
            rf_we = 1'b1;
        end
    end

    assign out_fire  = m_axis_tvalid && m_axis_tready;
    assign load_obuf = (state_reg == B_DONE) && !obuf_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        ld_next    = ld_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = B_ANGLE;
                end
            end
            B_ANGLE:
            begin
                if (ha_done[0])
                begin
                    ld_next    = 4'd0;
                    state_next = B_LOAD;
                end
            end
            B_LOAD:
            begin
                ld_next = ld_reg + 4'd1;
                if (ld_reg == 4'(R_SC2))
                begin
                    pc_next    = '0;
                    state_next = B_READ;
                end
            end
            B_READ:
            begin
                state_next = B_MULT;
            end
            B_MULT:
            begin
                state_next = B_WRITE;
            end
            B_WRITE:
            begin
                pc_next = pc_reg + PC_W'(1);
                if (pc_reg == PC_W'(PROG_LEN - 1))
                begin
                    state_next = B_DONE;
                end
                else
                begin
                    state_next = B_READ;
                end
            end
            B_DONE:
            begin
                if (!obuf_valid_reg)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        obuf_valid_next = obuf_valid_reg;
        col_next        = col_reg;
        if (load_obuf)
        begin
            obuf_valid_next = 1'b1;
            col_next        = 2'd0;
        end
        else if (out_fire)
        begin
            col_next = col_reg + 2'd1;
            if (col_reg == LAST_COL)
            begin
                obuf_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            pc_reg         <= '0;
            ld_reg         <= 4'd0;
            obuf_valid_reg <= 1'b0;
            col_reg        <= 2'd0;
        end
        else
        begin
            state_reg      <= state_next;
            pc_reg         <= pc_next;
            ld_reg         <= ld_next;
            obuf_valid_reg <= obuf_valid_next;
            col_reg        <= col_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ha_start)
        begin
            scale_reg <= item.scale;
            move_reg  <= item.move;
        end
        if (state_reg == B_MULT)
        begin
            prod_reg <= $signed(rf_rdata_a) * $signed(rf_rdata_b);
            opa_reg  <= $signed(rf_rdata_a);
            opb_reg  <= $signed(rf_rdata_b);
        end
        if ((state_reg == B_WRITE) && (cur.op == OP_SMUL))
        begin
            mw_reg[cur.dst[3:0]] <= sat_val;
        end
        if (load_obuf)
        begin
            for (int c = 0; c < N_AXES; c++)
            begin
                obuf_col_reg[c] <= {mw_reg[3*c+2], mw_reg[3*c+1], mw_reg[3*c]};
            end
            obuf_move_reg <= move_reg;
        end
    end

    always_comb
    begin
        case (col_reg)
            2'd0:    m_axis_tdata = {{WORD_W{1'b0}}, obuf_col_reg[0]};
            2'd1:    m_axis_tdata = {{WORD_W{1'b0}}, obuf_col_reg[1]};
            2'd2:    m_axis_tdata = {{WORD_W{1'b0}}, obuf_col_reg[2]};
            default: m_axis_tdata = {ROW3_ONE, obuf_move_reg};
        endcase
    end

    assign m_axis_tvalid = obuf_valid_reg;
    assign m_axis_tuser  = col_reg;
    assign m_axis_tlast  = (col_reg == LAST_COL);

endmodule

// ----- design/srt_transform_matrix_builder.sv -----
// Top level of the scale-rotate-translate matrix builder.
// Depends on srtmb_pkg, srtmb_front and srtmb_back.

// Each input item (scale, Euler angles in degrees and translation, Q16.16) yields a
// column-major 4x4 model matrix sent as four output items, column 0 first; tuser holds
// the column number and tlast marks column 3. In the back end an item passes a start
// state, the modulo-360 reduction (a reciprocal multiplication and a remainder step),
// the radian conversion and 30 CORDIC steps (three angles side by side), the done
// flag, 9 register-file loads and a 47-step program on one shared multiplier, each step
// in a read, a multiply and a write state, and last the hand-over of the matrix to the
// output buffer. A two-entry input queue and the output buffer let the next item be
// taken while the previous matrix is still being read out.
module srt_transform_matrix_builder import srtmb_pkg::*; #(
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // scale_x, scale_y, scale_z, angle_x, angle_y, angle_z, move_x, move_y, move_z
    input  logic [IN_W-1:0]  s_axis_tdata,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // entry_row0, entry_row1, entry_row2, entry_row3
    output logic [OUT_W-1:0] m_axis_tdata,
    // column_index
    output logic [1:0]       m_axis_tuser,
    output logic             m_axis_tlast
);

    in_item_t item;
    logic     item_valid;
    logic     item_pop;

    srtmb_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .item          (item),
        .item_valid    (item_valid),
        .item_pop      (item_pop)
    );

    srtmb_back #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .item          (item),
        .item_valid    (item_valid),
        .item_pop      (item_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
